// File: sv/cfa_pkg.sv
// ----------------------------------------------------------------------------
// cfa_pkg
// shared types and constants of the contiguous fit allocator
// ----------------------------------------------------------------------------
package cfa_pkg;

	localparam int NUM_BLOCKS_DEF = 32;
	localparam int TAG_BITS_DEF   = 8;

	// fixed payload widths
	localparam int REQ_W    = 6;
	localparam int OWNER_W  = 8;
	localparam int START_W  = 5;
	localparam int RUNLEN_W = 6;
	localparam int POL_W    = 2;

	typedef enum logic [POL_W-1:0] {
		POL_WORST = 2'd0,
		POL_BEST  = 2'd1,
		POL_FIRST = 2'd2
	} policy_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINAL,
		ST_EVAL,
		ST_FILL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic clear_wr;
		logic scan_rd;
		logic final_judge;
		logic eval;
		logic fill_wr;
		logic push_out;
	} cmd_t;

	typedef struct packed {
		logic reject;
		logic addr_last;
		logic ok;
		logic fill_last;
		logic out_busy;
	} status_t;

endpackage

// File: sv/cfa_req_if.sv
// ----------------------------------------------------------------------------
// cfa_req_if
// request channel: block count and owner tag
// ----------------------------------------------------------------------------
interface cfa_req_if;

	logic                      valid;
	logic                      ready;
	logic [cfa_pkg::REQ_W-1:0]   request_blocks;
	logic [cfa_pkg::OWNER_W-1:0] owner_tag;

	modport source (output valid, output request_blocks, output owner_tag, input ready);
	modport sink   (input valid, input request_blocks, input owner_tag, output ready);

endinterface

// File: sv/cfa_resp_if.sv
// ----------------------------------------------------------------------------
// cfa_resp_if
// response channel: grant flag, start block and chosen run length
// ----------------------------------------------------------------------------
interface cfa_resp_if;

	logic                         valid;
	logic                         ready;
	logic                         granted;
	logic [cfa_pkg::START_W-1:0]  start_block;
	logic [cfa_pkg::RUNLEN_W-1:0] run_length;

	modport source (output valid, output granted, output start_block, output run_length,
		input ready);
	modport sink   (input valid, input granted, input start_block, input run_length,
		output ready);

endinterface

// File: sv/cfa_ram.sv
// ----------------------------------------------------------------------------
// cfa_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module cfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/cfa_ctrl.sv
// ----------------------------------------------------------------------------
// cfa_ctrl
// sequencer: clear pass, map scan, run judging, block fill, response
// ----------------------------------------------------------------------------
module cfa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  cfa_pkg::status_t status,
	output cfa_pkg::cmd_t    cmd
);

	cfa_pkg::state_t state_q;
	cfa_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfa_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			cfa_pkg::ST_CLEAR: begin
				if (status.addr_last) state_d = cfa_pkg::ST_IDLE;
			end
			cfa_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = status.reject ? cfa_pkg::ST_DONE : cfa_pkg::ST_SCAN;
				end
			end
			cfa_pkg::ST_SCAN: begin
				if (status.addr_last) state_d = cfa_pkg::ST_DRAIN;
			end
			cfa_pkg::ST_DRAIN: state_d = cfa_pkg::ST_FINAL;
			cfa_pkg::ST_FINAL: state_d = cfa_pkg::ST_EVAL;
			cfa_pkg::ST_EVAL: begin
				state_d = status.ok ? cfa_pkg::ST_FILL : cfa_pkg::ST_DONE;
			end
			cfa_pkg::ST_FILL: begin
				if (status.fill_last) state_d = cfa_pkg::ST_DONE;
			end
			cfa_pkg::ST_DONE: begin
				if (!status.out_busy) state_d = cfa_pkg::ST_IDLE;
			end
			default: state_d = cfa_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			cfa_pkg::ST_CLEAR: cmd.clear_wr = 1'b1;
			cfa_pkg::ST_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
			end
			cfa_pkg::ST_SCAN:  cmd.scan_rd     = 1'b1;
			cfa_pkg::ST_DRAIN: cmd             = '0;
			cfa_pkg::ST_FINAL: cmd.final_judge = 1'b1;
			cfa_pkg::ST_EVAL:  cmd.eval        = 1'b1;
			cfa_pkg::ST_FILL:  cmd.fill_wr     = 1'b1;
			cfa_pkg::ST_DONE:  cmd.push_out    = !status.out_busy;
			default:           cmd             = '0;
		endcase
	end

endmodule

// File: sv/cfa_dp.sv
// ----------------------------------------------------------------------------
// cfa_dp
// datapath: policy register, run tracker, address counter, output register
// ----------------------------------------------------------------------------
module cfa_dp #(
	parameter int NUM_BLOCKS = cfa_pkg::NUM_BLOCKS_DEF,
	parameter int TAG_BITS   = cfa_pkg::TAG_BITS_DEF,
	localparam int IDX_W     = $clog2(NUM_BLOCKS),
	localparam int LEN_W     = $clog2(NUM_BLOCKS + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cfa_pkg::POL_W-1:0]     cfg_wdata,
	input  logic [cfa_pkg::REQ_W-1:0]     request_blocks,
	input  logic [cfa_pkg::OWNER_W-1:0]   owner_tag,
	input  cfa_pkg::cmd_t                 cmd,
	output cfa_pkg::status_t              status,
	// map memory access
	output logic                          mem_we,
	output logic [IDX_W-1:0]              mem_addr,
	output logic [TAG_BITS-1:0]           mem_wdata,
	input  logic [TAG_BITS-1:0]           mem_rdata,
	// response
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic                          out_granted,
	output logic [cfa_pkg::START_W-1:0]   out_start,
	output logic [cfa_pkg::RUNLEN_W-1:0]  out_len
);

	localparam int CMP_W = (LEN_W > cfa_pkg::REQ_W) ? LEN_W : cfa_pkg::REQ_W;

	logic [cfa_pkg::POL_W-1:0]    fit_policy_q;
	logic [cfa_pkg::REQ_W-1:0]    need_q;
	logic [TAG_BITS-1:0]          tag_q;
	logic [IDX_W-1:0]             addr_q;
	logic [LEN_W-1:0]             fill_left_q;
	logic                         vld_s1;
	logic [IDX_W-1:0]             idx_s1;
	logic [IDX_W-1:0]             run_start_q;
	logic [LEN_W-1:0]             run_len_q;
	logic                         have_q;
	logic [IDX_W-1:0]             best_start_q;
	logic [LEN_W-1:0]             best_len_q;
	logic                         ok_q;
	logic                         out_valid_q;
	logic                         granted_q;
	logic [cfa_pkg::START_W-1:0]  start_q;
	logic [cfa_pkg::RUNLEN_W-1:0] len_q;

	logic [TAG_BITS-1:0] tag_in;
	logic                pol_known;
	logic                blk_free;
	logic                run_open;
	logic                long_enough;
	logic                take;
	logic                judge_now;
	logic                ok;

	assign tag_in    = TAG_BITS'(owner_tag);
	assign pol_known = (fit_policy_q == cfa_pkg::POL_WORST) ||
		(fit_policy_q == cfa_pkg::POL_BEST) || (fit_policy_q == cfa_pkg::POL_FIRST);

	assign blk_free    = (mem_rdata == '0);
	assign run_open    = (run_len_q != '0);
	assign long_enough = CMP_W'(run_len_q) >= CMP_W'(need_q);

	// decide whether the current run replaces the chosen one
	always_comb begin
		case (cfa_pkg::policy_t'(fit_policy_q))
			cfa_pkg::POL_WORST: take = !have_q || (run_len_q > best_len_q);
			cfa_pkg::POL_BEST:  take = long_enough && (!have_q || (run_len_q < best_len_q));
			cfa_pkg::POL_FIRST: take = long_enough && !have_q;
			default:            take = 1'b0;
		endcase
	end

	// a run closes on an occupied block or at the end of the map
	assign judge_now = run_open && ((vld_s1 && !blk_free) || cmd.final_judge);

	assign ok = have_q && (CMP_W'(best_len_q) >= CMP_W'(need_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_policy_q <= '0;
			addr_q       <= '0;
			fill_left_q  <= '0;
			vld_s1       <= 1'b0;
			run_len_q    <= '0;
			have_q       <= 1'b0;
			ok_q         <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				fit_policy_q <= cfg_wdata;
			end
			vld_s1 <= cmd.scan_rd;

			if (cmd.accept) begin
				addr_q    <= '0;
				run_len_q <= '0;
				have_q    <= 1'b0;
				ok_q      <= 1'b0;
			end else if (cmd.clear_wr || cmd.scan_rd || cmd.fill_wr) begin
				addr_q <= addr_q + 1'b1;
			end else if (cmd.eval) begin
				addr_q <= best_start_q;
			end

			if (judge_now && take) begin
				have_q <= 1'b1;
			end
			if (vld_s1) begin
				if (blk_free) begin
					run_len_q <= run_len_q + 1'b1;
				end else begin
					run_len_q <= '0;
				end
			end

			if (cmd.eval) begin
				ok_q        <= ok;
				fill_left_q <= LEN_W'(need_q);
			end else if (cmd.fill_wr) begin
				fill_left_q <= fill_left_q - 1'b1;
			end

			if (cmd.push_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			need_q       <= request_blocks;
			tag_q        <= tag_in;
			best_start_q <= '0;
			best_len_q   <= '0;
		end else if (judge_now && take) begin
			best_start_q <= run_start_q;
			best_len_q   <= run_len_q;
		end
		idx_s1 <= addr_q;
		if (vld_s1 && blk_free && !run_open) begin
			run_start_q <= idx_s1;
		end
		if (cmd.push_out) begin
			granted_q <= ok_q;
			start_q   <= ok_q ? cfa_pkg::START_W'(best_start_q) : '0;
			len_q     <= ok_q ? cfa_pkg::RUNLEN_W'(best_len_q) : '0;
		end
	end

	assign status.reject    = (request_blocks == '0) || (tag_in == '0) || !pol_known;
	assign status.addr_last = (addr_q == IDX_W'(NUM_BLOCKS - 1));
	assign status.ok        = ok;
	assign status.fill_last = (fill_left_q == LEN_W'(1));
	assign status.out_busy  = out_valid_q && !out_ready;

	assign mem_we    = cmd.clear_wr || cmd.fill_wr;
	assign mem_addr  = addr_q;
	assign mem_wdata = cmd.fill_wr ? tag_q : '0;

	assign out_valid   = out_valid_q;
	assign out_granted = granted_q;
	assign out_start   = start_q;
	assign out_len     = len_q;

endmodule

// File: sv/contiguous_fit_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_fit_allocator
// worst / best / first fit allocator over a map of fixed-size blocks
// ----------------------------------------------------------------------------
// a request word is scanned over the map, its runs judged, the chosen run filled
//   and the response loaded, waiting out any stall of the previous response;
//   a failed request skips the fill, one rejected up front skips to the response
// one request at a time: the next is taken once the response is loaded
// reset: arst_n clears control and the policy register, then a clearing pass
//   over all NUM_BLOCKS blocks zeroes the map before the first request is taken
module contiguous_fit_allocator #(
	parameter int NUM_BLOCKS = cfa_pkg::NUM_BLOCKS_DEF,
	parameter int TAG_BITS   = cfa_pkg::TAG_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [cfa_pkg::POL_W-1:0] cfg_wdata,
	cfa_req_if.sink                   req,
	cfa_resp_if.source                rsp
);

	localparam int IDX_W = $clog2(NUM_BLOCKS);

	cfa_pkg::cmd_t    cmd;
	cfa_pkg::status_t status;

	logic                mem_we;
	logic [IDX_W-1:0]    mem_addr;
	logic [TAG_BITS-1:0] mem_wdata;
	logic [TAG_BITS-1:0] mem_rdata;

	cfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.status    (status),
		.cmd       (cmd)
	);

	cfa_dp #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.TAG_BITS   (TAG_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.request_blocks (req.request_blocks),
		.owner_tag      (req.owner_tag),
		.cmd            (cmd),
		.status         (status),
		.mem_we         (mem_we),
		.mem_addr       (mem_addr),
		.mem_wdata      (mem_wdata),
		.mem_rdata      (mem_rdata),
		.out_ready      (rsp.ready),
		.out_valid      (rsp.valid),
		.out_granted    (rsp.granted),
		.out_start      (rsp.start_block),
		.out_len        (rsp.run_length)
	);

	// block map: one owner tag per block, zero when free
	cfa_ram #(
		.WIDTH (TAG_BITS),
		.DEPTH (NUM_BLOCKS)
	) u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_addr),
		.wdata (mem_wdata),
		.raddr (mem_addr),
		.rdata (mem_rdata)
	);

endmodule

// File: sv/cfa_checker.sv
// ----------------------------------------------------------------------------
// cfa_checker
// port-level checks of the allocator, bound to the top level
// ----------------------------------------------------------------------------
module cfa_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         granted,
	input logic [cfa_pkg::START_W-1:0]  start_block,
	input logic [cfa_pkg::RUNLEN_W-1:0] run_length
);

	// stalled response word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({granted, start_block, run_length}))
		else $error("response word changed while stalled");

	// one request in flight: no second word taken right after one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while previous one is in work");

	// a failed request reports zero start and length
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !granted |-> (start_block == '0) && (run_length == '0))
		else $error("failed response carries nonzero fields");

	// a grant always comes from a nonempty run
	a_grant_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && granted |-> run_length != '0)
		else $error("grant with empty run");

endmodule

bind contiguous_fit_allocator cfa_checker u_cfa_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (req.valid),
	.in_ready    (req.ready),
	.out_valid   (rsp.valid),
	.out_ready   (rsp.ready),
	.granted     (rsp.granted),
	.start_block (rsp.start_block),
	.run_length  (rsp.run_length)
);
